FILE: rtl/core/hex_float_formatter_unit_macros.svh
// ----------------------------------------------------------------------------
// hex_float_formatter_unit_macros
// Assertion macros used by the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef HEX_FLOAT_FORMATTER_UNIT_MACROS_SVH
`define HEX_FLOAT_FORMATTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HFF_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hff assertion failed");

// next-cycle implication, disabled during reset
`define HFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hff assertion failed");

`endif

FILE: rtl/core/hff_pkg.sv
// ----------------------------------------------------------------------------
// hff_pkg
// Types and constants of the hex float formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package hff_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int FRAC_W = 52;
    localparam int EXP_W  = 11;
    localparam int MAG_W  = 10;
    localparam int POS_W  = 5;
    localparam int DEC_W  = 16;

    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [EXP_W-1:0] EXP_BIAS     = 11'd1023;
    localparam logic [MAG_W-1:0] SUB_MAG      = 10'd1022;
    localparam logic [7:0]       RECIP10      = 8'd205;

    // text positions of a finite nonzero number
    localparam logic [POS_W-1:0] POS_SIGN  = 5'd0;
    localparam logic [POS_W-1:0] POS_ZERO  = 5'd1;
    localparam logic [POS_W-1:0] POS_X     = 5'd2;
    localparam logic [POS_W-1:0] POS_LEAD  = 5'd3;
    localparam logic [POS_W-1:0] POS_POINT = 5'd4;
    localparam logic [POS_W-1:0] POS_FRAC  = 5'd5;
    localparam logic [POS_W-1:0] POS_P     = 5'd18;
    localparam logic [POS_W-1:0] POS_ESIGN = 5'd19;
    localparam logic [POS_W-1:0] POS_DEC   = 5'd20;

    localparam logic [POS_W-1:0] LAST_WORD = 5'd3;
    localparam logic [POS_W-1:0] LAST_ZERO = 5'd6;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_LC_I  = 8'h69;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        uppercase;
    } t_in_item;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_NAN,
        KIND_INF,
        KIND_ZERO,
        KIND_NUM
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              up;
        logic              sign_shown;
        logic              sub;
        logic              exp_neg;
        logic [FRAC_W-1:0] frac;
        logic [DEC_W-1:0]  dec_text;
        logic [POS_W-1:0]  last_pos;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_head;

endpackage

`default_nettype wire

FILE: rtl/core/hex_float_formatter_unit.sv
// ----------------------------------------------------------------------------
// hex_float_formatter_unit
// Formats binary64 bit patterns as %a / %A text, one character per item.
// ----------------------------------------------------------------------------
// Each input item (a 64-bit double pattern and a case flag) produces 3 to 24
// output items, one ASCII character each, the final one marked by last. The
// output register emits one character per cycle while the output is ready,
// and consecutive numbers stream with no gap. A two-stage front pipeline
// classifies each number and converts its exponent to decimal, then parks it
// in a four-entry job queue; the front keeps accepting numbers while the back
// is still printing, until the queue fills. A number passes through both front
// stages and the job queue before its first character reaches the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_float_formatter_unit (
    input  wire                    logic i_clk,
    input  wire                    logic i_rst_n,
    input  wire                    logic i_in_valid,
    output                         logic o_in_ready,
    input  wire hff_pkg::t_in_item     i_in_item,
    output                         logic o_out_valid,
    input  wire                    logic i_out_ready,
    output hff_pkg::t_out_item         o_out_item
);
    import hff_pkg::*;

    logic  w_job_valid;
    logic  w_job_ready;
    t_job  w_job;
    t_head w_head;
    logic  w_pop;

    hff_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    hff_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_job_valid),
        .o_wr_ready (w_job_ready),
        .i_wr_job   (w_job),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    hff_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hff_front.sv
// ----------------------------------------------------------------------------
// hff_front
// Classifies each number and converts its exponent to decimal digits.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_front (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output                     logic o_in_ready,
    input  wire hff_pkg::t_in_item i_in_item,
    output                     logic o_job_valid,
    input  wire                logic i_job_ready,
    output hff_pkg::t_job          o_job
);
    import hff_pkg::*;

    logic              w_adv1;
    logic              w_adv2;
    logic              w_neg;
    logic [EXP_W-1:0]  w_ef;
    logic [FRAC_W-1:0] w_frac;
    t_job              w_job;
    logic [MAG_W-1:0]  w_mag;

    logic              r_s1_valid;
    t_job              r_s1_job;
    logic [MAG_W-1:0]  r_s1_mag;

    logic [17:0]       w_prod1;
    logic [6:0]        w_q1;
    logic [MAG_W-1:0]  w_ten_q1;
    logic [MAG_W-1:0]  w_rem0;

    logic              r_s2_valid;
    t_job              r_s2_job;
    logic [6:0]        r_s2_q1;
    logic [3:0]        r_s2_d0;

    logic [14:0]       w_prod2;
    logic [3:0]        w_q2;
    logic [6:0]        w_ten_q2;
    logic [6:0]        w_rem1;
    logic [3:0]        w_d1;
    logic [3:0]        w_d2;
    logic [3:0]        w_d3;
    logic              w_ge10;
    logic [2:0]        w_nd;
    logic [DEC_W-1:0]  w_dec_text;

    assign w_adv2     = !r_s2_valid || i_job_ready;
    assign w_adv1     = !r_s1_valid || w_adv2;
    assign o_in_ready = w_adv1;

    assign w_neg  = i_in_item.value_bits[63];
    assign w_ef   = i_in_item.value_bits[62:52];
    assign w_frac = i_in_item.value_bits[51:0];

    always_comb begin
        w_job          = '0;
        w_job.up       = i_in_item.uppercase;
        w_job.sub      = (w_ef == '0);
        w_job.exp_neg  = (w_ef < EXP_BIAS);
        w_job.frac     = w_frac;
        priority if (w_ef == EXP_ALL_ONES) begin
            w_job.kind     = (|w_frac) ? KIND_NAN : KIND_INF;
            w_job.last_pos = LAST_WORD;
        end else if (w_ef == '0 && !(|w_frac)) begin
            w_job.kind     = KIND_ZERO;
            w_job.last_pos = LAST_ZERO;
        end else begin
            w_job.kind     = KIND_NUM;
            w_job.last_pos = POS_ESIGN;
        end
        w_job.sign_shown = w_neg && (w_job.kind == KIND_INF || w_job.kind == KIND_NUM);
        priority if (w_ef == '0) begin
            w_mag = SUB_MAG;
        end else if (w_job.exp_neg) begin
            w_mag = MAG_W'(EXP_BIAS - w_ef);
        end else begin
            w_mag = MAG_W'(w_ef - EXP_BIAS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_adv1) begin
            r_s1_job <= w_job;
            r_s1_mag <= w_mag;
        end
    end

    // lowest decimal digit: multiply by reciprocal of ten
    assign w_prod1  = 18'(r_s1_mag) * 18'(RECIP10);
    assign w_q1     = w_prod1[17:11];
    assign w_ten_q1 = MAG_W'({w_q1, 3'b000}) + MAG_W'({w_q1, 1'b0});
    assign w_rem0   = r_s1_mag - w_ten_q1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_adv2) begin
            r_s2_job <= r_s1_job;
            r_s2_q1  <= w_q1;
            r_s2_d0  <= w_rem0[3:0];
        end
    end

    // remaining digits; quotient after two steps stays at or below ten
    assign w_prod2  = 15'(r_s2_q1) * 15'(RECIP10);
    assign w_q2     = w_prod2[14:11];
    assign w_ten_q2 = 7'({w_q2, 3'b000}) + 7'({w_q2, 1'b0});
    assign w_rem1   = r_s2_q1 - w_ten_q2;
    assign w_d1     = w_rem1[3:0];
    assign w_ge10   = (w_q2 >= 4'd10);
    assign w_d3     = w_ge10 ? 4'd1 : 4'd0;
    assign w_d2     = w_ge10 ? (w_q2 - 4'd10) : w_q2;

    always_comb begin
        priority if (r_s2_q1 == '0) begin
            w_nd       = 3'd1;
            w_dec_text = {r_s2_d0, 12'h000};
        end else if (w_q2 == '0) begin
            w_nd       = 3'd2;
            w_dec_text = {w_d1, r_s2_d0, 8'h00};
        end else if (!w_ge10) begin
            w_nd       = 3'd3;
            w_dec_text = {w_d2, w_d1, r_s2_d0, 4'h0};
        end else begin
            w_nd       = 3'd4;
            w_dec_text = {w_d3, w_d2, w_d1, r_s2_d0};
        end
    end

    always_comb begin
        o_job          = r_s2_job;
        o_job.dec_text = w_dec_text;
        if (r_s2_job.kind == KIND_NUM) begin
            o_job.last_pos = POS_ESIGN + POS_W'(w_nd);
        end
    end

    assign o_job_valid = r_s2_valid;

endmodule

`default_nettype wire

FILE: rtl/core/hff_queue.sv
// ----------------------------------------------------------------------------
// hff_queue
// Short job queue between the classifying front and the text back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hff_queue (
    input  wire            logic i_clk,
    input  wire            logic i_rst_n,
    input  wire            logic i_wr_valid,
    output                 logic o_wr_ready,
    input  wire hff_pkg::t_job i_wr_job,
    output hff_pkg::t_head     o_head,
    input  wire            logic i_pop
);
    import hff_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   w_wr;

    assign o_wr_ready   = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign w_wr         = i_wr_valid && o_wr_ready;
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({w_wr, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hff_back.sv
// ----------------------------------------------------------------------------
// hff_back
// Walks the text of the head job and emits one character per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_float_formatter_unit_macros.svh"

module hff_back (
    input  wire                 logic i_clk,
    input  wire                 logic i_rst_n,
    input  wire hff_pkg::t_head     i_head,
    output                      logic o_pop,
    output                      logic o_out_valid,
    input  wire                 logic i_out_ready,
    output hff_pkg::t_out_item      o_out_item
);
    import hff_pkg::*;

    function automatic logic [7:0] text_char(t_job job, logic [POS_W-1:0] pos);
        logic [7:0] ch;
        logic       letter;
        logic [3:0] fi;
        logic [1:0] di;
        logic [3:0] nib;
        ch     = CH_0;
        letter = 1'b0;
        fi     = 4'(pos - POS_FRAC);
        di     = 2'(pos - POS_DEC);
        nib    = 4'(job.frac >> (6'd48 - {fi, 2'b00}));
        unique case (job.kind)
            KIND_NAN: begin
                letter = 1'b1;
                ch     = (pos == POS_X) ? CH_LC_A : CH_LC_N;
            end
            KIND_INF: begin
                priority if (pos == POS_SIGN) begin
                    ch = CH_MINUS;
                end else begin
                    letter = 1'b1;
                    ch = (pos == POS_ZERO) ? CH_LC_I : ((pos == POS_X) ? CH_LC_N : CH_LC_F);
                end
            end
            KIND_ZERO: begin
                priority if (pos == POS_X) begin
                    letter = 1'b1;
                    ch     = CH_LC_X;
                end else if (pos == POS_POINT) begin
                    letter = 1'b1;
                    ch     = CH_LC_P;
                end else if (pos == POS_FRAC) begin
                    ch = CH_PLUS;
                end else begin
                    ch = CH_0;
                end
            end
            KIND_NUM: begin
                priority if (pos == POS_SIGN) begin
                    ch = CH_MINUS;
                end else if (pos == POS_ZERO) begin
                    ch = CH_0;
                end else if (pos == POS_X) begin
                    letter = 1'b1;
                    ch     = CH_LC_X;
                end else if (pos == POS_LEAD) begin
                    ch = job.sub ? CH_0 : CH_1;
                end else if (pos == POS_POINT) begin
                    ch = CH_POINT;
                end else if (pos < POS_P) begin
                    if (nib < 4'd10) begin
                        ch = CH_0 + 8'(nib);
                    end else begin
                        letter = 1'b1;
                        ch     = CH_LC_A + 8'(nib) - 8'd10;
                    end
                end else if (pos == POS_P) begin
                    letter = 1'b1;
                    ch     = CH_LC_P;
                end else if (pos == POS_ESIGN) begin
                    ch = job.exp_neg ? CH_MINUS : CH_PLUS;
                end else begin
                    ch = CH_0 + 8'(4'(job.dec_text >> (5'd12 - {di, 2'b00})));
                end
            end
        endcase
        if (letter && job.up) begin
            ch = ch - CASE_OFFSET;
        end
        return ch;
    endfunction

    logic [POS_W-1:0] r_step;
    logic [POS_W-1:0] w_pos;
    logic             w_load;
    logic             w_last;
    logic             r_out_valid;
    t_out_item        r_out_item;

    assign w_pos  = r_step + POS_W'(!i_head.job.sign_shown);
    assign w_last = (w_pos == i_head.job.last_pos);
    assign w_load = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_load && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_step <= w_last ? '0 : r_step + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item.character <= text_char(i_head.job, w_pos);
            r_out_item.last      <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `HFF_ASSERT(a_pos_in_text, i_clk, i_rst_n, i_head.valid, w_pos <= i_head.job.last_pos)
    `HFF_ASSERT_NEXT(a_step_clears, i_clk, i_rst_n, o_pop, r_step == '0)
    `HFF_ASSERT(a_sign_first, i_clk, i_rst_n, i_head.valid && w_pos == POS_SIGN, i_head.job.sign_shown && r_step == '0)

endmodule

`default_nettype wire
